FILE: hdl/hprc_pkg.sv
// ----------------------------------------------------------------------------
// hprc_pkg: shared types, stage schedule and arithmetic helpers
// Holds the per-stage item record of the hit reconstruction pipeline, the
// stage numbering and one function that forms each stage's combinational work.
// ----------------------------------------------------------------------------
`default_nettype none

package hprc_pkg;

    localparam int COORD_BITS     = 24;
    localparam int FRAC_BITS      = 12;
    localparam int CFG_INDEX_BITS = 3;

    // register indexes of the configuration channel
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FOCUS_LINEAR    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FOCUS_QUADRATIC = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REFRACTION      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CATHODE_RADIUS  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_RADIUS   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Z_BASE          = 3'd5;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // stage schedule: stage s forms register s from register s-1
    localparam int ST_SQUARE     = 1;
    localparam int ST_SQ1_FIRST  = 2;
    localparam int ST_SQ1_LAST   = 25;
    localparam int ST_PROD       = 26;
    localparam int ST_DISC       = 27;
    localparam int ST_SQ2_FIRST  = 28;
    localparam int ST_SQ2_LAST   = 58;
    localparam int ST_DSET       = 59;
    localparam int ST_OVF1       = 60;
    localparam int ST_DIV1_FIRST = 61;
    localparam int ST_DIV1_LAST  = 84;
    localparam int ST_SCALE      = 85;
    localparam int ST_K3         = 86;
    localparam int ST_U2         = 87;
    localparam int ST_U2R        = 88;
    localparam int ST_U1         = 89;
    localparam int ST_U1R        = 90;
    localparam int ST_RN         = 91;
    localparam int ST_PROD2      = 92;
    localparam int ST_SET2       = 93;
    localparam int ST_OVF2       = 94;
    localparam int ST_DIV2_FIRST = 95;
    localparam int ST_DIV2_LAST  = 118;
    localparam int ST_SQ3_FIRST  = 95;
    localparam int ST_SQ3_LAST   = 117;
    localparam int ST_OUT        = 119;
    localparam int N_STAGES      = ST_OUT + 1;

    localparam int QUOT_BITS = 24;
    localparam int LANES     = 3;

    typedef struct packed {
        logic signed [31:0]           b;
        logic signed [31:0]           q;
        logic [63:0]                  k;
        logic [22:0]                  cr;
        logic [22:0]                  wr;
        logic signed [COORD_BITS-1:0] zb;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]      x;
        logic signed [COORD_BITS-1:0]      y;
        logic                              corr;
        logic                              inv;
        logic [63:0]                       sq_v;
        logic [63:0]                       sq_r;
        logic [54:0]                       b2;
        logic [23:0]                       rsi;
        logic signed [63:0]                t;
        logic signed [63:0]                u;
        logic                              dok;
        logic [63:0]                       den;
        logic [LANES-1:0][63:0]            rem;
        logic [LANES-1:0]                  neg;
        logic [LANES-1:0]                  ovf;
        logic [LANES-1:0][QUOT_BITS-1:0]   quo;
        logic signed [COORD_BITS-1:0]      xp;
        logic signed [COORD_BITS-1:0]      yp;
        logic signed [COORD_BITS-1:0]      rp;
        logic signed [COORD_BITS-1:0]      rn;
        logic signed [47:0]                p0;
        logic signed [47:0]                p1;
        logic [47:0]                       rsq;
        logic [47:0]                       m2;
        logic                              in_sphere;
        logic [22:0]                       maxr;
        logic signed [COORD_BITS-1:0]      cz;
    } item_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // clamp a wide signed value to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [63:0] v);
        if (v > 64'(COORD_MAX)) return COORD_MAX;
        if (v < 64'(COORD_MIN)) return COORD_MIN;
        return v[COORD_BITS-1:0];
    endfunction

    // apply sign and clamp to a rounded quotient magnitude
    function automatic logic signed [COORD_BITS-1:0] sat_quot(input logic neg,
                                                              input logic ovf,
                                                              input logic [QUOT_BITS-1:0] q);
        if (ovf) return neg ? COORD_MIN : COORD_MAX;
        if (!neg) return q[QUOT_BITS-1] ? COORD_MAX : q;
        if (q > QUOT_BITS'(COORD_MIN)) return COORD_MIN;
        return COORD_BITS'(0 - q);
    endfunction

    // combinational work of stage s
    function automatic item_t hprc_stage(input int s, input cfg_t c, input item_t d);
        item_t               o;
        int                  k;
        logic [63:0]         bitv;
        logic [63:0]         dk;
        logic [63:0]         ud;
        logic signed [47:0]  sx;
        logic signed [47:0]  sy;
        logic signed [47:0]  sr;
        logic signed [63:0]  bb;
        logic signed [56:0]  m57;
        logic signed [63:0]  disc;
        logic signed [63:0]  dv;
        logic signed [63:0]  cc;
        logic signed [28:0]  u29;
        logic signed [39:0]  u40;
        logic signed [15:0]  k0;
        logic signed [15:0]  k1;
        logic signed [15:0]  k2;
        logic signed [15:0]  k3;
        logic [22:0]         dz;
        logic                active;
        o  = d;
        k0 = $signed(c.k[15:0]);
        k1 = $signed(c.k[31:16]);
        k2 = $signed(c.k[47:32]);
        k3 = $signed(c.k[63:48]);

        // square the hit and the linear term
        if (s == ST_SQUARE) begin
            sx     = d.x * d.x;
            sy     = d.y * d.y;
            o.sq_v = 64'(sx) + 64'(sy);
            o.sq_r = '0;
            bb     = c.b * c.b;
            o.b2   = bb[62:8];
        end

        // one root bit per stage
        if ((s >= ST_SQ1_FIRST && s <= ST_SQ1_LAST) || (s >= ST_SQ2_FIRST && s <= ST_SQ2_LAST)
            || (s >= ST_SQ3_FIRST && s <= ST_SQ3_LAST)) begin
            if (s <= ST_SQ1_LAST)      k = ST_SQ1_LAST - s;
            else if (s <= ST_SQ2_LAST) k = ST_SQ2_LAST - s;
            else                       k = ST_SQ3_LAST - s;
            bitv = 64'd1 << (2 * k);
            if (d.sq_v >= d.sq_r + bitv) begin
                o.sq_v = d.sq_v - (d.sq_r + bitv);
                o.sq_r = (d.sq_r >> 1) + bitv;
            end else begin
                o.sq_r = d.sq_r >> 1;
            end
        end

        // hit radius times quadratic term
        if (s == ST_PROD) begin
            o.rsi = d.sq_r[23:0];
            m57   = $signed({1'b0, d.sq_r[23:0]}) * c.q;
            o.t   = 64'(m57);
        end

        // discriminant and its sign
        if (s == ST_DISC) begin
            disc   = $signed({9'b0, d.b2}) - (d.t <<< (18 - FRAC_BITS));
            active = (c.b != 0) && (d.rsi != 0) && (c.q != 0);
            o.inv  = active && disc[63];
            o.sq_v = disc[63] ? 64'd0 : 64'(disc);
            o.sq_r = '0;
        end

        // denominator and rounded-division operands
        if (s == ST_DSET) begin
            if (c.q == 0) dv = 64'(c.b) <<< 1;
            else          dv = 64'(c.b) - $signed(d.sq_r << 4);
            o.dok    = (c.b != 0) && (d.rsi != 0) && !d.inv && (dv != 0);
            ud       = mag64(dv);
            o.den    = ud << 1;
            o.u      = dv;
            o.rem[0] = (mag64(64'(d.x)) << 26) + ud;
            o.rem[1] = (mag64(64'(d.y)) << 26) + ud;
            o.rem[2] = (64'(d.rsi) << 26) + ud;
            o.neg[0] = d.x[COORD_BITS-1] ^ dv[63];
            o.neg[1] = d.y[COORD_BITS-1] ^ dv[63];
            o.neg[2] = dv[63];
        end

        // flag quotients beyond the kept bits
        if (s == ST_OVF1 || s == ST_OVF2) begin
            for (int i = 0; i < LANES; i++) begin
                o.ovf[i] = d.rem[i] >= (d.den << QUOT_BITS);
                o.quo[i] = '0;
            end
        end

        // one quotient bit per stage
        if ((s >= ST_DIV1_FIRST && s <= ST_DIV1_LAST)
            || (s >= ST_DIV2_FIRST && s <= ST_DIV2_LAST)) begin
            if (s <= ST_DIV1_LAST) k = ST_DIV1_LAST - s;
            else                   k = ST_DIV2_LAST - s;
            dk = d.den << k;
            for (int i = 0; i < LANES; i++) begin
                if (d.rem[i] >= dk) begin
                    o.rem[i]    = d.rem[i] - dk;
                    o.quo[i][k] = 1'b1;
                end
            end
        end

        // scaled cathode coordinates
        if (s == ST_SCALE) begin
            o.xp = d.dok ? sat_quot(d.neg[0], d.ovf[0], d.quo[0]) : '0;
            o.yp = d.dok ? sat_quot(d.neg[1], d.ovf[1], d.quo[1]) : '0;
            o.rp = d.dok ? sat_quot(d.neg[2], d.ovf[2], d.quo[2]) : '0;
        end

        // refraction polynomial by Horner's rule
        if (s == ST_K3) o.t = k3 * d.rp;
        if (s == ST_U2) o.u = (64'(k2) <<< 9) + (d.t >>> (FRAC_BITS - 1));
        if (s == ST_U2R) begin
            u29 = d.u[28:0];
            o.t = u29 * d.rp;
        end
        if (s == ST_U1) o.u = (64'(k1) <<< 17) + (d.t >>> FRAC_BITS);
        if (s == ST_U1R) begin
            u40 = d.u[39:0];
            o.t = u40 * d.rp;
        end
        if (s == ST_RN) begin
            cc   = 64'(k0) + (d.t >>> 32);
            o.rn = sat_coord(64'(d.rp) + cc);
        end

        // products for rescale and depth
        if (s == ST_PROD2) begin
            o.p0 = d.xp * d.rn;
            o.p1 = d.yp * d.rn;
            sx   = d.xp * d.xp;
            sy   = d.yp * d.yp;
            sr   = d.rn * d.rn;
            o.rsq  = d.corr ? 48'(sr) : 48'(sx) + 48'(sy);
            o.maxr = d.corr ? c.wr : c.cr;
            o.m2   = 48'(o.maxr) * 48'(o.maxr);
        end

        // rescale operands and depth radicand
        if (s == ST_SET2) begin
            o.dok       = d.corr && (d.rp != 0);
            ud          = mag64(64'(d.rp));
            o.den       = ud << 1;
            o.rem[0]    = (mag64(64'(d.p0)) << 1) + ud;
            o.rem[1]    = (mag64(64'(d.p1)) << 1) + ud;
            o.rem[2]    = '0;
            o.neg[0]    = d.p0[47] ^ d.rp[COORD_BITS-1];
            o.neg[1]    = d.p1[47] ^ d.rp[COORD_BITS-1];
            o.neg[2]    = 1'b0;
            o.in_sphere = d.m2 > d.rsq;
            o.sq_v      = o.in_sphere ? 64'(d.m2 - d.rsq) : 64'd0;
            o.sq_r      = '0;
        end

        // final coordinates and z
        if (s == ST_OUT) begin
            o.xp = d.dok ? sat_quot(d.neg[0], d.ovf[0], d.quo[0]) : d.xp;
            o.yp = d.dok ? sat_quot(d.neg[1], d.ovf[1], d.quo[1]) : d.yp;
            dz   = d.in_sphere ? d.sq_r[22:0] : d.maxr;
            o.cz = sat_coord(64'(c.zb) + 64'(dz));
        end
        return o;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hit_to_photocathode_reconstruct.sv
// ----------------------------------------------------------------------------
// hit_to_photocathode_reconstruct: silicon hit to photocathode point
// Fixed-point pipeline: hit radius, demagnification inversion, scaling,
// optional refraction correction and spherical depth.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------
//  input     | start, busy             | hit_x, hit_y, apply_correction
//  result    | done (one-cycle strobe) | cathode_x, cathode_y, cathode_z, invalid
//  config    | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
//  One item enters per cycle; busy stays low. Each item passes through the
//  stage registers in order, a chain set by the bit-per-stage root and quotient
//  steps (three roots, two rounds of rounded division).
//  Reset clears the valid bits and the configuration registers.
//  Nothing stalls: results are shown for one cycle and taken then.
// ----------------------------------------------------------------------------
`default_nettype none

module hit_to_photocathode_reconstruct (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [hprc_pkg::COORD_BITS-1:0] hit_x,
    input  logic signed [hprc_pkg::COORD_BITS-1:0] hit_y,
    input  logic                                  apply_correction,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hprc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [63:0]                           cfg_data,
    output logic                                  done,
    output logic signed [hprc_pkg::COORD_BITS-1:0] cathode_x,
    output logic signed [hprc_pkg::COORD_BITS-1:0] cathode_y,
    output logic signed [hprc_pkg::COORD_BITS-1:0] cathode_z,
    output logic                                  invalid
);
    import hprc_pkg::*;

    cfg_t                cfg_reg;
    item_t               pipe_reg  [N_STAGES];
    item_t               pipe_next [N_STAGES];
    logic [N_STAGES-1:0] valid_reg;
    logic                accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FOCUS_LINEAR:    cfg_reg.b  <= $signed(cfg_data[31:0]);
                CFG_FOCUS_QUADRATIC: cfg_reg.q  <= $signed(cfg_data[31:0]);
                CFG_REFRACTION:      cfg_reg.k  <= cfg_data;
                CFG_CATHODE_RADIUS:  cfg_reg.cr <= cfg_data[22:0];
                CFG_WINDOW_RADIUS:   cfg_reg.wr <= cfg_data[22:0];
                CFG_Z_BASE:          cfg_reg.zb <= $signed(cfg_data[COORD_BITS-1:0]);
                default:             ;
            endcase
        end
    end

    // capture the input item
    always_comb
    begin
        pipe_next[0]      = '0;
        pipe_next[0].x    = hit_x;
        pipe_next[0].y    = hit_y;
        pipe_next[0].corr = apply_correction;
    end

    // stage logic
    for (genvar s = 1; s < N_STAGES; s++)
    begin : g_stage
        always_comb
        begin
            pipe_next[s] = hprc_stage(s, cfg_reg, pipe_reg[s-1]);
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < N_STAGES; s++)
        begin
            pipe_reg[s] <= pipe_next[s];
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[N_STAGES-2:0], accept};
        end
    end

    assign done      = valid_reg[N_STAGES-1];
    assign cathode_x = pipe_reg[N_STAGES-1].xp;
    assign cathode_y = pipe_reg[N_STAGES-1].yp;
    assign cathode_z = pipe_reg[N_STAGES-1].cz;
    assign invalid   = pipe_reg[N_STAGES-1].inv;

    // a result comes only from an item taken a fixed latency earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, N_STAGES))
        else $error("result without matching item");

    // a negative discriminant leaves x and y at zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && invalid) |-> (cathode_x == 0 && cathode_y == 0))
        else $error("invalid result with nonzero coordinates");

    // the pipeline never holds off input
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy && cfg_ready)
        else $error("input held off");

endmodule

`default_nettype wire

FILE: verif/hprc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hprc_checker: result predictor and scoreboard for the hit reconstruction
// Tracks configuration writes, computes the expected cathode point for each
// accepted hit and compares every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module hprc_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic                                   busy,
    input  wire logic signed [hprc_pkg::COORD_BITS-1:0] hit_x,
    input  wire logic signed [hprc_pkg::COORD_BITS-1:0] hit_y,
    input  wire logic                                   apply_correction,
    input  wire logic                                   cfg_valid,
    input  wire logic                                   cfg_ready,
    input  wire logic [hprc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [63:0]                            cfg_data,
    input  wire logic                                   done,
    input  wire logic signed [hprc_pkg::COORD_BITS-1:0] cathode_x,
    input  wire logic signed [hprc_pkg::COORD_BITS-1:0] cathode_y,
    input  wire logic signed [hprc_pkg::COORD_BITS-1:0] cathode_z,
    input  wire logic                                   invalid,
    output int                                          fail_count,
    output int                                          outstanding
);
    import hprc_pkg::*;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
        logic                         bad_disc;
    } point_t;

    // shadow copy of the configuration registers
    longint          lin_coef;
    longint          quad_coef;
    logic [63:0]     refr_coefs;
    longint          cath_rad;
    longint          win_rad;
    longint          z_offset;

    point_t          point_q[$];

    function automatic longint clamp_coord(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // rounded division, ties away from zero
    function automatic longint round_div(longint n, longint d);
        longint unsigned un;
        longint unsigned ud;
        longint unsigned qt;
        un = n < 0 ? longint'(0) - n : n;
        ud = d < 0 ? longint'(0) - d : d;
        qt = (2 * un + ud) / (2 * ud);
        return ((n < 0) != (d < 0)) ? -longint'(qt) : longint'(qt);
    endfunction

    // cubic window refraction offset for radius r
    function automatic longint refraction_offset(longint r);
        longint k0;
        longint k1;
        longint k2;
        longint k3;
        longint u2;
        longint u1;
        k0 = longint'($signed(refr_coefs[15:0]));
        k1 = longint'($signed(refr_coefs[31:16]));
        k2 = longint'($signed(refr_coefs[47:32]));
        k3 = longint'($signed(refr_coefs[63:48]));
        u2 = k2 * 512 + ((k3 * r) >>> (FRAC_BITS - 1));
        u1 = k1 * (longint'(1) <<< 17) + ((u2 * r) >>> FRAC_BITS);
        return k0 + ((u1 * r) >>> 32);
    endfunction

    function automatic point_t predict_point(longint x, longint y, logic corr);
        point_t          p;
        longint          xs;
        longint          ys;
        longint          rs;
        longint          rsi;
        longint          den;
        longint          disc;
        longint          rn;
        longint          lim;
        longint          rho2;
        longint          depth;
        logic            den_ok;
        longint unsigned bsq;
        xs = 0;
        ys = 0;
        rs = 0;
        p.bad_disc = 1'b0;
        if (lin_coef != 0)
        begin
            rsi = int_sqrt(x * x + y * y);
            if (rsi != 0)
            begin
                den    = 0;
                den_ok = 1'b1;
                if (quad_coef == 0)
                    den = 2 * lin_coef;
                else
                begin
                    bsq  = longint'(lin_coef * lin_coef);
                    disc = longint'(bsq >> 8)
                           - rsi * quad_coef * (longint'(4) <<< (16 - FRAC_BITS));
                    if (disc < 0)
                    begin
                        p.bad_disc = 1'b1;
                        den_ok     = 1'b0;
                    end
                    else
                        den = lin_coef - 16 * longint'(int_sqrt(disc));
                end
                if (den_ok && den != 0)
                begin
                    xs = clamp_coord(round_div(x * (longint'(1) <<< 25), den));
                    ys = clamp_coord(round_div(y * (longint'(1) <<< 25), den));
                    rs = clamp_coord(round_div(rsi * (longint'(1) <<< 25), den));
                end
            end
        end
        lim  = cath_rad;
        rho2 = xs * xs + ys * ys;
        if (corr)
        begin
            rn   = clamp_coord(rs + refraction_offset(rs));
            lim  = win_rad;
            rho2 = rn * rn;
            if (rs != 0)
            begin
                xs = clamp_coord(round_div(xs * rn, rs));
                ys = clamp_coord(round_div(ys * rn, rs));
            end
        end
        if (lim * lim > rho2) depth = int_sqrt(lim * lim - rho2);
        else                  depth = lim;
        p.px = xs[COORD_BITS-1:0];
        p.py = ys[COORD_BITS-1:0];
        p.pz = COORD_BITS'(clamp_coord(z_offset + depth));
        return p;
    endfunction

    assign outstanding = point_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
        begin
            lin_coef   <= 0;
            quad_coef  <= 0;
            refr_coefs <= '0;
            cath_rad   <= 0;
            win_rad    <= 0;
            z_offset   <= 0;
            fail_count <= 0;
        end
        else
        begin
            // track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FOCUS_LINEAR:    lin_coef   <= longint'($signed(cfg_data[31:0]));
                    CFG_FOCUS_QUADRATIC: quad_coef  <= longint'($signed(cfg_data[31:0]));
                    CFG_REFRACTION:      refr_coefs <= cfg_data;
                    CFG_CATHODE_RADIUS:  cath_rad   <= longint'(cfg_data[22:0]);
                    CFG_WINDOW_RADIUS:   win_rad    <= longint'(cfg_data[22:0]);
                    CFG_Z_BASE:          z_offset   <= longint'($signed(cfg_data[23:0]));
                    default: ;
                endcase
            end
            // predict each accepted hit
            if (start && !busy)
                point_q = {point_q, predict_point(longint'(hit_x), longint'(hit_y),
                                                  apply_correction)};
            // compare each result against the oldest prediction
            if (done)
            begin
                if (point_q.size() == 0)
                begin
                    $error("result with no hit outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = point_q.pop_front();
                    if (cathode_x !== want.px || cathode_y !== want.py
                        || cathode_z !== want.pz || invalid !== want.bad_disc)
                    begin
                        fail_count <= fail_count + 1;
                        if (cathode_x !== want.px)
                            $error("cathode_x expected %0d got %0d", want.px, cathode_x);
                        if (cathode_y !== want.py)
                            $error("cathode_y expected %0d got %0d", want.py, cathode_y);
                        if (cathode_z !== want.pz)
                            $error("cathode_z expected %0d got %0d", want.pz, cathode_z);
                        if (invalid !== want.bad_disc)
                            $error("invalid expected %0d got %0d", want.bad_disc, invalid);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: verif/hit_to_photocathode_reconstruct_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hit_to_photocathode_reconstruct_test: stimulus and verdict
// Programs the focus, refraction and sphere registers through several
// settings and sends directed then random hits with random gaps; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module hit_to_photocathode_reconstruct_test;
    import hprc_pkg::*;

    localparam int DRAIN_CYCLES = 140;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [COORD_BITS-1:0]  hit_x;
    logic signed [COORD_BITS-1:0]  hit_y;
    logic                          apply_correction;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [63:0]                   cfg_data;
    logic                          done;
    logic signed [COORD_BITS-1:0]  cathode_x;
    logic signed [COORD_BITS-1:0]  cathode_y;
    logic signed [COORD_BITS-1:0]  cathode_z;
    logic                          invalid;
    int                            fail_count;
    int                            outstanding;

    hit_to_photocathode_reconstruct u_top (.*);

    hprc_checker u_checker (.*);

    always #1 clk = ~clk;

    // hard stop
    initial
    begin
        #3000000;
        $display("hit_to_photocathode_reconstruct: mismatch");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // present one register write; valid stays up for a following write
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // hold until every prediction is met, then let the pipe empty
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_all(logic [31:0] b, logic [31:0] q, logic [63:0] k,
                               logic [22:0] cr, logic [22:0] wr, logic [23:0] zb);
        write_reg(CFG_FOCUS_LINEAR, {32'd0, b});
        write_reg(CFG_FOCUS_QUADRATIC, {32'd0, q});
        write_reg(CFG_REFRACTION, k);
        write_reg(CFG_CATHODE_RADIUS, {41'd0, cr});
        write_reg(CFG_WINDOW_RADIUS, {41'd0, wr});
        write_reg(CFG_Z_BASE, {40'd0, zb});
        cfg_valid <= 1'b0;
    endtask

    // present one hit and hold it until accepted
    task automatic send_hit(logic [23:0] x, logic [23:0] y, logic corr);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start            <= 1'b1;
        hit_x            <= x;
        hit_y            <= y;
        apply_correction <= corr;
        do @(posedge clk); while (busy);
    endtask

    function automatic logic [23:0] rand_coord();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2, 3:    return 24'($urandom);
            4:       return 24'($signed($urandom_range(0, 400)) - 200);
            default: return 24'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    task automatic random_settings();
        logic [31:0] b;
        logic [31:0] q;
        logic [63:0] k;
        int          mode;
        mode = $urandom_range(0, 5);
        // mostly realistic demagnification: small negative linear term
        b = (mode == 0) ? $urandom : -($urandom_range(1, 1 << 23) + 32'd1000);
        case ($urandom_range(0, 3))
            0:       q = 32'd0;
            1:       q = $urandom;
            default: q = 32'($signed($urandom_range(0, 4000)) - 2000);
        endcase
        k = (mode == 1) ? {$urandom, $urandom}
            : {16'($signed($urandom_range(0, 64)) - 32),
               16'($signed($urandom_range(0, 512)) - 256),
               16'($signed($urandom_range(0, 4096)) - 2048),
               16'($signed($urandom_range(0, 2000)) - 1000)};
        program_all(b, q, k, 23'($urandom), 23'($urandom),
                    (mode == 2) ? 24'($urandom) : 24'($urandom_range(0, 1 << 20)));
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        start            = 1'b0;
        hit_x            = '0;
        hit_y            = '0;
        apply_correction = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero linear term
        send_hit(24'd1000, 24'd2000, 1'b0);
        send_hit(24'd1000, 24'd2000, 1'b1);
        drain();

        // linear only, with correction and radii
        program_all(-32'sd4194304, 32'd0, 64'h0010_FF00_0100_0040,
                    23'd40960, 23'd45056, 24'd1000);
        send_hit(24'd0, 24'd0, 1'b0);
        send_hit(24'd0, 24'd0, 1'b1);
        send_hit(24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_hit(24'h800000, 24'h800000, 1'b1);
        send_hit(24'h7FFFFF, 24'h800000, 1'b0);
        send_hit(24'd4096, 24'hFFF000, 1'b1);
        send_hit(24'd1, 24'd0, 1'b0);
        send_hit(24'd2000, 24'd3000, 1'b1);
        drain();

        // quadratic term: both signs of discriminant
        program_all(-32'sd4194304, 32'h7FFFFFFF, 64'h7FFF_7FFF_7FFF_7FFF,
                    23'h7FFFFF, 23'h7FFFFF, 24'h7FFFFF);
        send_hit(24'd10, 24'd0, 1'b0);
        send_hit(24'd40000, 24'd40000, 1'b1);
        send_hit(24'h800000, 24'd0, 1'b0);
        send_hit(24'd0, 24'd0, 1'b1);
        drain();
        program_all(32'h7FFFFFFF, 32'h80000000, 64'h8000_8000_8000_8000,
                    23'd0, 23'd0, 24'h800000);
        send_hit(24'd5000, 24'd7000, 1'b0);
        send_hit(24'h7FFFFF, 24'h7FFFFF, 1'b1);
        send_hit(24'd1, 24'd1, 1'b1);
        drain();
        program_all(32'h80000000, 32'hFFFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    23'd100, 23'd50, 24'h7FFFF0);
        send_hit(24'd5000, 24'h800000, 1'b0);
        send_hit(24'hFFFFFF, 24'd3, 1'b1);
        send_hit(24'd30000, 24'd30000, 1'b1);
        drain();

        // random settings, random hits
        for (int phase = 0; phase < 8; phase++)
        begin
            random_settings();
            for (int n = 0; n < 80; n++)
            begin
                send_hit(rand_coord(), rand_coord(), 1'($urandom));
                // let the pipe run dry once mid-phase
                if (phase == 3 && n == 40)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    while (outstanding != 0) @(posedge clk);
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("hit_to_photocathode_reconstruct: match");
        else
            $display("hit_to_photocathode_reconstruct: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

FILE: hit_to_photocathode_reconstruct.f
hdl/hprc_pkg.sv
hdl/hit_to_photocathode_reconstruct.sv
verif/hprc_checker.sv
verif/hit_to_photocathode_reconstruct_test.sv
